// ===== hdl/inorm_pkg.sv =====
package inorm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = 23;
    localparam int EPS_W    = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd168;

    localparam int DIFF_W   = 24;   // x*n - sum
    localparam int ACC_W    = 51;   // sum of squared differences
    localparam int N3_W     = 19;   // n^3
    localparam int VAR_W    = 34;   // variance + epsilon fits here
    localparam int SQ_IN_W  = 58;
    localparam int ROOT_W   = 29;
    localparam int DEN_W    = 36;   // n * root
    localparam int NUM_W    = 40;   // scale * diff
    localparam int DIV_NW   = 52;
    localparam int DIV_DW   = 38;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

// ===== hdl/inorm_if.sv =====
interface inorm_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [inorm_pkg::SAMPLE_W-1:0] sample;
    logic signed [inorm_pkg::SAMPLE_W-1:0] channel_scale;
    logic signed [inorm_pkg::SAMPLE_W-1:0] channel_bias;
    logic                              last_in_channel;

    modport source (output valid, sample, channel_scale, channel_bias, last_in_channel,
                    input ready);
    modport sink   (input valid, sample, channel_scale, channel_bias, last_in_channel,
                    output ready);
endinterface

interface inorm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [inorm_pkg::SAMPLE_W-1:0] normalized_value;
    logic                              last_out;
    logic                              overflow;

    modport source (output valid, normalized_value, last_out, overflow, input ready);
    modport sink   (input valid, normalized_value, last_out, overflow, output ready);
endinterface

interface inorm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [inorm_pkg::EPS_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/inorm_div.sv =====
module inorm_div #(
    parameter int NW = 52,
    parameter int DW = 38
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;

    assign rem_sh = {r_rem, r_q[NW-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (!diff[DW]) begin
                r_rem <= diff[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
endmodule

// ===== hdl/inorm_sqrt.sv =====
module inorm_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [inorm_pkg::SQ_IN_W-1:0]   i_val,
    output logic                            o_busy,
    output logic [inorm_pkg::ROOT_W-1:0]    o_root
);
    localparam int VW = inorm_pkg::SQ_IN_W;
    localparam int RW = inorm_pkg::ROOT_W;
    localparam int CW = $clog2(RW + 1);

    logic [CW-1:0]   r_cnt;
    logic [VW-1:0]   r_val;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;

    assign rem_sh = {r_rem, r_val[VW-1:VW-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign diff   = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(RW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_val <= {r_val[VW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= diff[RW+1:0];
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[RW+1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;
endmodule

// ===== hdl/instance_normalization.sv =====
// Instance normalization over one channel instance at a time.
// i_in carries one sample per beat with the channel's scale and bias; the beat
// with last_in_channel set closes the instance (its scale and bias are used).
// Up to MAX_CHANNEL_SIZE samples are held in a sample RAM; extra
// samples are dropped and every result of that run has overflow set.
// i_cfg writes epsilon (Q8.24); write only while the block is idle.
// o_out gives one beat per stored sample, in input order, last_out on the last.
// Throughput: a non-last sample is taken every cycle while the block is in its
// input state. After the last sample the block is busy with the variance pass
// over the RAM, the variance divide, the root and then each result in turn,
// computed by the bit-serial divider shared between both divides.
// The output beat is held in a register: while the receiver stalls the next
// result is computed and waits, and i_in is taken again once the final result
// sits in that register.
// Reset (synchronous, active low) empties the run and sets epsilon to 168.
module instance_normalization #(
    parameter int MAX_CHANNEL_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    inorm_in_if.sink    i_in,
    inorm_cfg_if.sink   i_cfg,
    inorm_out_if.source o_out
);
    localparam int AW = (MAX_CHANNEL_SIZE > 1) ? $clog2(MAX_CHANNEL_SIZE) : 1;
    localparam int CNW = inorm_pkg::COUNT_W;
    localparam logic [CNW-1:0] CAP = CNW'(MAX_CHANNEL_SIZE);

    localparam logic [3:0] S_IN   = 4'd0;
    localparam logic [3:0] S_VRD  = 4'd1;
    localparam logic [3:0] S_VD   = 4'd2;
    localparam logic [3:0] S_VSQ  = 4'd3;
    localparam logic [3:0] S_VDIV = 4'd4;
    localparam logic [3:0] S_VWT  = 4'd5;
    localparam logic [3:0] S_SQ   = 4'd6;
    localparam logic [3:0] S_SQWT = 4'd7;
    localparam logic [3:0] S_ERD  = 4'd8;
    localparam logic [3:0] S_ED   = 4'd9;
    localparam logic [3:0] S_EM   = 4'd10;
    localparam logic [3:0] S_EDIV = 4'd11;
    localparam logic [3:0] S_EWT  = 4'd12;

    logic [3:0] r_state;

    logic [inorm_pkg::EPS_W-1:0]     r_eps;
    logic [CNW-1:0]                  r_count;
    logic signed [inorm_pkg::SUM_W-1:0] r_sum;
    logic                            r_drop;

    logic [CNW-1:0]                  r_cnt;
    logic signed [inorm_pkg::SUM_W-1:0] r_csum;
    logic                            r_ovf;
    inorm_pkg::t_sample              r_scale;
    inorm_pkg::t_sample              r_bias;

    logic [CNW-1:0]                  r_idx;
    inorm_pkg::t_sample              r_rd;
    logic [inorm_pkg::SAMPLE_W-1:0]  mem [MAX_CHANNEL_SIZE];

    logic signed [inorm_pkg::DIFF_W-1:0] r_d;
    logic [inorm_pkg::ACC_W-1:0]     r_acc;
    logic [13:0]                     r_n2;
    logic [inorm_pkg::N3_W-1:0]      r_n3;
    logic [inorm_pkg::DEN_W-1:0]     r_den;
    logic [inorm_pkg::NUM_W-2:0]     r_anum;
    logic                            r_neg;

    logic                            r_ov;
    inorm_pkg::t_sample              r_oval;
    logic                            r_olast;
    logic                            r_oovf;

    logic                            acc_in;
    logic                            keep;
    logic signed [inorm_pkg::SUM_W-1:0] sum_nx;
    logic signed [7:0]               n_s;
    logic signed [inorm_pkg::DIFF_W-1:0] d_cur;
    logic [inorm_pkg::DIFF_W-1:0]    ad;
    logic signed [inorm_pkg::NUM_W-1:0] num;
    logic [inorm_pkg::VAR_W:0]       veps;
    logic [inorm_pkg::ROOT_W-1:0]    root1;

    logic                            div_start;
    logic [inorm_pkg::DIV_NW-1:0]    div_num;
    logic [inorm_pkg::DIV_DW-1:0]    div_den;
    logic                            div_busy;
    logic [inorm_pkg::DIV_NW-1:0]    div_q;
    logic                            sq_start;
    logic                            sq_busy;
    logic [inorm_pkg::ROOT_W-1:0]    sq_root;

    logic signed [inorm_pkg::DIV_NW+1:0] y;
    inorm_pkg::t_sample              y_sat;
    logic                            out_free;
    logic                            emit;

    assign i_in.ready  = (r_state == S_IN);
    assign i_cfg.ready = 1'b1;
    assign acc_in      = i_in.valid && i_in.ready;
    assign keep        = (r_count < CAP);
    assign sum_nx      = keep ? (r_sum + inorm_pkg::SUM_W'(i_in.sample)) : r_sum;

    assign n_s   = {1'b0, r_cnt};
    assign d_cur = inorm_pkg::DIFF_W'(r_rd * n_s) - inorm_pkg::DIFF_W'(r_csum);
    assign ad    = r_d[inorm_pkg::DIFF_W-1] ? inorm_pkg::DIFF_W'(-r_d) : r_d;
    assign num   = inorm_pkg::NUM_W'(r_scale * r_d);
    assign veps  = (inorm_pkg::VAR_W+1)'(div_q[inorm_pkg::VAR_W-1:0]) + r_eps;
    assign root1 = (sq_root == '0) ? inorm_pkg::ROOT_W'(1) : sq_root;

    assign out_free = !r_ov || o_out.ready;
    assign emit     = (r_state == S_EWT) && !div_busy && out_free;

    always_comb begin
        y = r_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
        y = y + (inorm_pkg::DIV_NW+2)'(r_bias);
        if (y > 32767) begin
            y_sat = 16'sh7FFF;
        end else if (y < -32768) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y[15:0];
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (r_state == S_VDIV) begin
            div_start = 1'b1;
            div_num   = inorm_pkg::DIV_NW'(r_acc);
            div_den   = inorm_pkg::DIV_DW'(r_n3);
        end else if (r_state == S_EDIV) begin
            div_start = 1'b1;
            div_num   = {r_anum, 13'b0} + inorm_pkg::DIV_NW'(r_den);
            div_den   = {1'b0, r_den, 1'b0};
        end
    end

    assign sq_start = (r_state == S_SQ);

    inorm_div #(.NW(inorm_pkg::DIV_NW), .DW(inorm_pkg::DIV_DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    inorm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   ({veps[inorm_pkg::VAR_W-1:0], 24'b0}),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // sample RAM
    always_ff @(posedge i_clk) begin
        if (acc_in && keep) begin
            mem[r_count[AW-1:0]] <= i_in.sample;
        end
        r_rd <= mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= inorm_pkg::EPS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_eps <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IN: begin
                    if (acc_in) begin
                        if (i_in.last_in_channel) begin
                            r_cnt   <= keep ? r_count + 1'b1 : r_count;
                            r_csum  <= sum_nx;
                            r_ovf   <= r_drop || !keep;
                            r_scale <= i_in.channel_scale;
                            r_bias  <= i_in.channel_bias;
                            r_count <= '0;
                            r_sum   <= '0;
                            r_drop  <= 1'b0;
                            r_idx   <= '0;
                            r_acc   <= '0;
                            r_state <= S_VRD;
                        end else if (keep) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= sum_nx;
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                S_VRD: begin
                    r_n2    <= 14'(r_cnt * r_cnt);
                    r_state <= S_VD;
                end
                S_VD: begin
                    r_d     <= d_cur;
                    r_n3    <= inorm_pkg::N3_W'(r_n2 * r_cnt);
                    r_state <= S_VSQ;
                end
                S_VSQ: begin
                    r_acc <= r_acc + inorm_pkg::ACC_W'(ad * ad);
                    if (r_idx + 1'b1 == r_cnt) begin
                        r_idx   <= '0;
                        r_state <= S_VDIV;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_VRD;
                    end
                end
                S_VDIV: r_state <= S_VWT;
                S_VWT: begin
                    if (!div_busy) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_SQWT;
                S_SQWT: begin
                    if (!sq_busy) begin
                        r_den   <= inorm_pkg::DEN_W'(r_cnt * root1);
                        r_state <= S_ERD;
                    end
                end
                S_ERD: r_state <= S_ED;
                S_ED: begin
                    r_d     <= d_cur;
                    r_state <= S_EM;
                end
                S_EM: begin
                    r_neg   <= num[inorm_pkg::NUM_W-1];
                    r_anum  <= num[inorm_pkg::NUM_W-1] ? (inorm_pkg::NUM_W-1)'(-num)
                                                       : num[inorm_pkg::NUM_W-2:0];
                    r_state <= S_EDIV;
                end
                S_EDIV: r_state <= S_EWT;
                S_EWT: begin
                    if (emit) begin
                        r_oval  <= y_sat;
                        r_olast <= (r_idx + 1'b1 == r_cnt);
                        r_oovf  <= r_ovf;
                        if (r_idx + 1'b1 == r_cnt) begin
                            r_state <= S_IN;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.normalized_value = r_oval;
    assign o_out.last_out         = r_olast;
    assign o_out.overflow         = r_oovf;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("sample count beyond capacity");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IN) |-> (r_idx < r_cnt))
        else $error("pass index beyond run length");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_in.last_in_channel) |=> (r_state == S_VRD && r_cnt != '0))
        else $error("last beat did not start the variance pass");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWT && !div_busy && r_ov && !o_out.ready) |=> $stable(r_oval))
        else $error("pending result overwritten");
endmodule

// ===== sim/inorm_checker.sv =====
`timescale 1ns / 1ps
module inorm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    inorm_in_if.sink    i_in,
    inorm_cfg_if.sink   i_cfg,
    inorm_out_if.sink   o_out,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int CAPACITY = 64;

    typedef struct packed {
        logic signed [15:0] value;
        logic               last_mark;
        logic               dropped;
    } t_norm_result;

    t_norm_result       expected_q[$];
    inorm_pkg::t_sample held_samples[CAPACITY];
    int                 held_count;
    longint             held_sum;
    logic               drop_seen;
    logic [31:0]        eps_reg;

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    task automatic close_instance(input longint scale, input longint bias);
        longint n, d, num, den, y;
        longint unsigned sumsq, var_q, root, an, q;
        t_norm_result r;
        n = held_count;
        sumsq = 0;
        for (int i = 0; i < held_count; i++) begin
            d = longint'(held_samples[i]) * n - held_sum;
            if (d < 0) d = -d;
            sumsq += d * d;
        end
        var_q = sumsq / (n * n * n);
        root = int_sqrt((var_q + eps_reg) << 24);
        if (root == 0) root = 1;
        den = n * longint'(root);
        for (int i = 0; i < held_count; i++) begin
            d = longint'(held_samples[i]) * n - held_sum;
            num = scale * d;
            an = (num < 0 ? -num : num);
            an = an << 12;
            q = (an * 2 + den) / (den * 2);
            y = (num < 0) ? -longint'(q) : longint'(q);
            y += bias;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            r.value = y[15:0];
            r.last_mark = (i + 1 == held_count);
            r.dropped = drop_seen;
            expected_q.push_back(r);
        end
        held_count = 0;
        held_sum = 0;
        drop_seen = 0;
    endtask

    always @(posedge i_clk) begin
        t_norm_result e;
        if (!i_rst_n) begin
            held_count <= 0;
            held_sum <= 0;
            drop_seen <= 0;
            eps_reg <= inorm_pkg::EPS_RESET;
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) eps_reg = i_cfg.data;
            if (i_in.valid && i_in.ready) begin
                if (held_count < CAPACITY) begin
                    held_samples[held_count] = i_in.sample;
                    held_sum += i_in.sample;
                    held_count++;
                end else begin
                    drop_seen = 1;
                end
                if (i_in.last_in_channel)
                    close_instance(i_in.channel_scale, i_in.channel_bias);
            end
            if (o_out.valid && o_out.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat value=%0d", o_out.normalized_value);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (o_out.normalized_value !== e.value) begin
                        $error("normalized_value exp %0d got %0d", e.value,
                               o_out.normalized_value);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (o_out.last_out !== e.last_mark) begin
                        $error("last_out exp %0b got %0b", e.last_mark, o_out.last_out);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (o_out.overflow !== e.dropped) begin
                        $error("overflow exp %0b got %0b", e.dropped, o_out.overflow);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

// ===== sim/instance_normalization_tb.sv =====
`timescale 1ns / 1ps
module instance_normalization_tb;
    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles;
    int   sent_items;

    inorm_in_if  in_ch();
    inorm_cfg_if cfg_ch();
    inorm_out_if out_ch();

    instance_normalization dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_cfg(cfg_ch), .o_out(out_ch)
    );

    inorm_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_cfg(cfg_ch), .o_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // watchdog: cycles with no accepted beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // valid stays up after a beat until an idle gap or drain_block drops it
    task automatic send_sample(input logic signed [15:0] s, input logic signed [15:0] sc,
                               input logic signed [15:0] b, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.sample <= s;
        in_ch.channel_scale <= sc;
        in_ch.channel_bias <= b;
        in_ch.last_in_channel <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic drain_block();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_eps(input logic [31:0] v);
        drain_block();
        cfg_ch.valid <= 1;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    function automatic logic [15:0] rand_value(input int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(2048)) - 16'd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    // one channel instance: len+1 samples, last one marked
    task automatic send_instance(input int len);
        int mode;
        logic [15:0] sc, b;
        mode = $urandom_range(5);
        sc = rand_value($urandom_range(5));
        b = rand_value($urandom_range(5));
        for (int i = 0; i < len; i++)
            send_sample(rand_value(mode == 4 ? $urandom_range(3) : mode),
                        16'($urandom), 16'($urandom), 1'b0);
        send_sample(rand_value(mode == 4 ? $urandom_range(3) : mode), sc, b, 1'b1);
    endtask

    initial begin
        int len;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.sample = 0;
        in_ch.channel_scale = 0;
        in_ch.channel_bias = 0;
        in_ch.last_in_channel = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        out_ch.ready = 0;
        idle_pct = 0;
        stall_pct = 0;
        sent_items = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: single sample, extremes, constant channel (zero variance), epsilon 0 and maximum
        send_sample(16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        send_sample(16'h1000, 16'h1000, 16'h0000, 1'b0);
        send_sample(16'h1000, 16'h1000, 16'h0000, 1'b0);
        send_sample(16'h1000, 16'h1000, 16'h0100, 1'b1);
        write_eps(32'd0);
        send_sample(16'h0005, 16'h1000, 16'h0000, 1'b0);
        send_sample(16'h0005, 16'h1000, 16'h0000, 1'b1);
        send_sample(16'h0000, 16'h7FFF, 16'h0000, 1'b0);
        send_sample(16'h0001, 16'h7FFF, 16'h0000, 1'b1);
        write_eps(32'hFFFF_FFFF);
        send_sample(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
        write_eps(32'd168);
        // full store: 64 kept, extras dropped, last one dropped too
        send_instance(66);
        drain_block();

        // random phases with different idle/stall mixes and epsilon settings
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 11 : 76) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 11 : 76) : 0;
            case (ph)
                0: write_eps(32'd168);
                1: write_eps(32'd0);
                2: write_eps($urandom);
                default: write_eps(32'h0100_0000);
            endcase
            while (sent_items < 120 * (ph + 1)) begin
                case ($urandom_range(9))
                    0: len = 63 + $urandom_range(2);
                    1: len = 0;
                    default: len = $urandom_range(12);
                endcase
                send_instance(len);
            end
        end
        idle_pct = 0;
        stall_pct = 0;
        drain_block();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/inorm_pkg.sv
hdl/inorm_if.sv
hdl/inorm_div.sv
hdl/inorm_sqrt.sv
hdl/instance_normalization.sv
sim/inorm_checker.sv
sim/instance_normalization_tb.sv
